@@ hdl/pts_pkg.sv @@
package pts_pkg;

  // field widths fixed by the item format
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 32;
  localparam int COUNT_W = 32;
  localparam int POS_W   = 7;
  localparam int ALU_W   = 32;

  // parameter defaults
  localparam int DEF_TABLE_DEPTH  = 64;
  localparam int DEF_BASE_TICK_HZ = 1000000;

  // shortest tone in whole wave periods
  localparam logic [COUNT_W-1:0] MIN_PERIODS = COUNT_W'(10);
  // position reported once the last tone has ended
  localparam logic [POS_W-1:0] FINISHED_MARK = POS_W'(64);

  // item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

endpackage

@@ hdl/pts_alu.sv @@
// shared 32-bit adder / subtractor, carry out is the no-borrow flag on subtract
module pts_alu
  import pts_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             sub,
  output logic [ALU_W-1:0] sum,
  output logic             carry
);

  logic [ALU_W-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, sub};

endmodule

@@ hdl/pts_tables.sv @@
// tone table: frequency and period count per entry, one write and one registered read
module pts_tables
  import pts_pkg::*;
#(
  parameter int DEPTH = DEF_TABLE_DEPTH,
  parameter int AW    = $clog2(DEF_TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [FREQ_W-1:0]  wr_freq,
  input  logic [COUNT_W-1:0] wr_count,
  input  logic [AW-1:0]      rd_addr,
  output logic [FREQ_W-1:0]  rd_freq,
  output logic [COUNT_W-1:0] rd_count
);

  logic [FREQ_W-1:0]  freq_mem  [DEPTH];
  logic [COUNT_W-1:0] count_mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_mem[wr_addr]  <= wr_freq;
      count_mem[wr_addr] <= wr_count;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_freq  <= freq_mem[rd_addr];
    rd_count <= count_mem[rd_addr];
  end

endmodule

@@ hdl/pwm_tone_sequencer.sv @@
// Square-wave tone sequencer. Each item (load, start, tick) is taken on start while busy
// is low and gives exactly one result, shown for one cycle with valid high; the receiver
// cannot stall it, so it must take every valid cycle. playing and current_entry are valid
// in that cycle. Multiply and divide steps run one per cycle through one 32-bit adder:
// a load runs 16 shift-add multiply steps and a store, a start fetches the entry, loads
// the divider and runs Q restoring divide steps, where Q is the bit width of BASE_TICK_HZ
// (20 at 1 MHz), and a tick ends at once, goes through a count state at the end of a wave
// period, and fetches and divides anew when that period moves playback to the next entry.
module pwm_tone_sequencer
  import pts_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int BASE_TICK_HZ = DEF_BASE_TICK_HZ
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    opcode,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic [FREQ_W-1:0]  tone_freq_hz,
  input  logic [DUR_W-1:0]   duration_ms,
  input  logic               config_write,
  input  logic [IDX_W-1:0]   config_data,
  output logic               valid,
  output logic               pin_level,
  output logic               playing,
  output logic [POS_W-1:0]   current_entry,
  output logic               sequence_done
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = $clog2(BASE_TICK_HZ + 1);
  localparam int IW = $clog2((QW > FREQ_W) ? QW : FREQ_W);
  localparam logic [QW-1:0] BASE_BITS = QW'(BASE_TICK_HZ);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MUL      = 7'b0000010,
    S_STORE    = 7'b0000100,
    S_FETCH    = 7'b0001000,
    S_DIVLOAD  = 7'b0010000,
    S_DIV      = 7'b0100000,
    S_TICK_CNT = 7'b1000000
  } state_t;

  state_t state;

  // playback state
  logic [POS_W-1:0]   tone_position;
  logic [COUNT_W-1:0] periods_elapsed;
  logic [FREQ_W-1:0]  wave_counter;
  logic [FREQ_W-1:0]  wrap_value;
  logic [FREQ_W-1:0]  high_level;
  logic               running;
  logic [IDX_W-1:0]   last_entry_index;

  // latched item and working registers
  op_t                ld_op;
  logic [IDX_W-1:0]   ld_idx;
  logic [FREQ_W-1:0]  ld_freq;
  logic [DUR_W-1:0]   ld_dur;
  logic [FREQ_W-1:0]  mul_f;
  logic [ALU_W-1:0]   acc;
  logic [IW-1:0]      iter;
  logic [QW-1:0]      dvd;
  logic [FREQ_W-1:0]  divisor;
  logic [FREQ_W-1:0]  rem;
  logic [FREQ_W-2:0]  quot;

  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  logic               alu_sub;
  logic [ALU_W-1:0]   alu_sum;
  logic               alu_carry;

  logic [FREQ_W-1:0]  rd_freq;
  logic [COUNT_W-1:0] rd_count;
  logic               wr_en;
  logic [COUNT_W-1:0] store_count;

  logic [FREQ_W:0]    rem_sh;
  logic [FREQ_W-1:0]  quot_next;
  logic [FREQ_W-1:0]  in_freq;
  logic               level_now;
  logic [POS_W-1:0]   final_pos;
  logic [POS_W-1:0]   pos_next;
  logic               tone_over;
  logic               seq_over;

  assign busy          = (state != S_IDLE);
  assign playing       = running;
  assign current_entry = tone_position;

  // level at the present counter
  assign level_now = running && (wave_counter < high_level);
  assign in_freq   = (tone_freq_hz == '0) ? FREQ_W'(1) : tone_freq_hz;

  // last entry played, limited to the table
  always_comb begin
    if (32'(last_entry_index) > 32'(TABLE_DEPTH - 1)) begin
      final_pos = POS_W'(TABLE_DEPTH - 1);
    end else begin
      final_pos = POS_W'(last_entry_index);
    end
  end

  assign pos_next  = tone_position + POS_W'(1);
  assign tone_over = (periods_elapsed > rd_count);
  assign seq_over  = tone_over && (pos_next > final_pos);

  // divide step operands
  assign rem_sh    = {rem, dvd[QW-1]};
  assign quot_next = {quot, alu_carry};

  // shared unit operand select: divide step or multiply step
  always_comb begin
    if (state == S_DIV) begin
      alu_a   = ALU_W'(rem_sh);
      alu_b   = ALU_W'(divisor);
      alu_sub = 1'b1;
    end else begin
      alu_a   = {acc[ALU_W-2:0], 1'b0};
      alu_b   = mul_f[FREQ_W-1] ? ld_dur : '0;
      alu_sub = 1'b0;
    end
  end

  pts_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // period count of a loaded entry, with the minimum applied
  always_comb begin
    store_count = COUNT_W'(acc[ALU_W-1:10]);
    if (store_count < MIN_PERIODS) begin
      store_count = MIN_PERIODS;
    end
  end

  assign wr_en = (state == S_STORE) && (32'(ld_idx) < 32'(TABLE_DEPTH));

  pts_tables #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_tables (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (AW'(ld_idx)),
    .wr_freq  (ld_freq),
    .wr_count (store_count),
    .rd_addr  (AW'(tone_position)),
    .rd_freq  (rd_freq),
    .rd_count (rd_count)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_entry_index <= '0;
    end else if (config_write) begin
      last_entry_index <= config_data;
    end
  end

  // sequencer and playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      valid           <= 1'b0;
      tone_position   <= '0;
      periods_elapsed <= '0;
      wave_counter    <= '0;
      wrap_value      <= '0;
      high_level      <= '0;
      running         <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (op_t'(opcode))
              OP_LOAD: begin
                state <= S_MUL;
              end
              OP_START: begin
                tone_position <= '0;
                wave_counter  <= '0;
                state         <= S_FETCH;
              end
              OP_TICK: begin
                if (!running) begin
                  valid <= 1'b1;
                end else if (wave_counter >= wrap_value) begin
                  wave_counter    <= '0;
                  periods_elapsed <= periods_elapsed + COUNT_W'(1);
                  state           <= S_TICK_CNT;
                end else begin
                  wave_counter <= wave_counter + FREQ_W'(1);
                  valid        <= 1'b1;
                end
              end
              default: begin
                valid <= 1'b1;
              end
            endcase
          end
        end
        S_MUL: begin
          if (iter == '0) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          valid <= 1'b1;
          state <= S_IDLE;
        end
        S_FETCH: begin
          state <= S_DIVLOAD;
        end
        S_DIVLOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (iter == '0) begin
            wrap_value      <= quot_next;
            high_level      <= quot_next >> 1;
            periods_elapsed <= COUNT_W'(1);
            running         <= 1'b1;
            valid           <= 1'b1;
            state           <= S_IDLE;
          end
        end
        S_TICK_CNT: begin
          if (seq_over) begin
            running       <= 1'b0;
            tone_position <= FINISHED_MARK;
            valid         <= 1'b1;
            state         <= S_IDLE;
          end else if (tone_over) begin
            tone_position <= pos_next;
            state         <= S_FETCH;
          end else begin
            valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          ld_op         <= op_t'(opcode);
          ld_idx        <= entry_index;
          ld_freq       <= in_freq;
          ld_dur        <= duration_ms;
          mul_f         <= in_freq;
          acc           <= '0;
          iter          <= IW'(FREQ_W - 1);
          pin_level     <= level_now;
          sequence_done <= 1'b0;
        end
      end
      S_MUL: begin
        acc   <= alu_sum;
        mul_f <= mul_f << 1;
        iter  <= iter - IW'(1);
      end
      S_DIVLOAD: begin
        divisor <= (rd_freq == '0) ? FREQ_W'(1) : rd_freq;
        rem     <= '0;
        dvd     <= BASE_BITS;
        quot    <= '0;
        iter    <= IW'(QW - 1);
      end
      S_DIV: begin
        rem  <= alu_carry ? alu_sum[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
        quot <= quot_next[FREQ_W-2:0];
        dvd  <= dvd << 1;
        iter <= iter - IW'(1);
        // a start reports the level at the fresh counter
        if (iter == '0 && ld_op == OP_START) begin
          pin_level <= (quot_next[FREQ_W-1:1] != '0);
        end
      end
      S_TICK_CNT: begin
        sequence_done <= seq_over;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/pts_checker.sv @@
// port-level checks on the tone sequencer
module pts_checker
  import pts_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             valid,
  input logic             pin_level,
  input logic             playing,
  input logic [POS_W-1:0] current_entry,
  input logic             sequence_done
);

  logic accept;
  logic outstanding;

  assign accept = start && !busy;

  // one item in flight between its transfer in and its result
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 1'b0;
    end else if (accept) begin
      outstanding <= 1'b1;
    end else if (valid) begin
      outstanding <= 1'b0;
    end
  end

  // every result belongs to an accepted item
  a_result_owned: assert property (@(posedge clk) disable iff (rst)
    valid |-> outstanding)
    else $error("result without an accepted item");

  // no new item while the previous result is still owed
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!outstanding || valid))
    else $error("item accepted before previous result");

  // an accepted item either starts work or reports at once
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || valid))
    else $error("accepted item neither busy nor reported");

  // end of sequence leaves the block stopped at the finished mark
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (valid && sequence_done) |-> (!playing && current_entry == FINISHED_MARK))
    else $error("sequence end without stop");

  // pin stays low when stopped
  a_quiet_stopped: assert property (@(posedge clk) disable iff (rst)
    (valid && !playing) |-> !pin_level)
    else $error("pin high while stopped");

endmodule

bind pwm_tone_sequencer pts_checker u_pts_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .valid         (valid),
  .pin_level     (pin_level),
  .playing       (playing),
  .current_entry (current_entry),
  .sequence_done (sequence_done)
);

@@ sim/tb_pwm_tone_sequencer.sv @@
module tb_pwm_tone_sequencer
  import pts_pkg::*;
();

  // opcode left unassigned by the block
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // cycles allowed after the last result before the block counts as idle
  localparam int SETTLE_CYCLES = 40;
  // least number of input items, idle ticks apart, sent over the whole run
  localparam int ITEM_TARGET = 750;

  typedef struct packed {
    logic             pin;
    logic             playing;
    logic [POS_W-1:0] entry;
    logic             done;
  } tone_result_t;

  // tone table predictor and queue of predicted results
  class tone_scoreboard;
    logic [FREQ_W-1:0]  freq_tab [DEF_TABLE_DEPTH];
    logic [COUNT_W-1:0] count_tab [DEF_TABLE_DEPTH];
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] periods;
    logic [15:0]        wave;
    logic [15:0]        wrap;
    logic [15:0]        high_mark;
    logic               running;
    logic [IDX_W-1:0]   last_idx;
    tone_result_t       pending_results [$];
    int                 errors;
    int                 finished_runs;

    function new();
      position = '0;
      periods = '0;
      wave = '0;
      wrap = '0;
      high_mark = '0;
      running = 1'b0;
      last_idx = '0;
      errors = 0;
      finished_runs = 0;
    endfunction

    // new tone: wave length from the base rate, first period under way
    function void enter_tone(int p);
      logic [31:0] f;
      logic [31:0] q;
      f = {16'd0, freq_tab[p]};
      if (f == 0) f = 1;
      q = 32'(DEF_BASE_TICK_HZ) / f;
      wrap = q[15:0];
      high_mark = wrap >> 1;
      periods = 1;
    endfunction

    function logic level();
      return running && (wave < high_mark);
    endfunction

    // predict the result of one accepted item
    function void note_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                            logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur);
      tone_result_t       r;
      logic [FREQ_W-1:0]  f;
      logic [COUNT_W-1:0] prod;
      logic [COUNT_W-1:0] cnt;
      int                 nxt;
      r.done = 1'b0;
      case (op)
        OP_LOAD: begin
          f = (freq == 0) ? FREQ_W'(1) : freq;
          prod = dur * {16'd0, f};
          cnt = prod >> 10;
          if (cnt < MIN_PERIODS) cnt = MIN_PERIODS;
          freq_tab[idx] = f;
          count_tab[idx] = cnt;
          r.pin = level();
        end
        OP_START: begin
          position = '0;
          wave = '0;
          enter_tone(0);
          running = 1'b1;
          r.pin = level();
        end
        OP_TICK: begin
          r.pin = level();
          if (running) begin
            if (wave >= wrap) begin
              wave = '0;
              periods = periods + 1;
              if (periods > count_tab[position]) begin
                nxt = position + 1;
                if (nxt > last_idx) begin
                  running = 1'b0;
                  position = FINISHED_MARK;
                  r.done = 1'b1;
                  finished_runs++;
                end else begin
                  position = POS_W'(nxt);
                  enter_tone(nxt);
                end
              end
            end else begin
              wave = wave + 16'd1;
            end
          end
        end
        default: r.pin = level();
      endcase
      r.playing = running;
      r.entry = position;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one result transfer against the oldest prediction
    function void check_result(tone_result_t got);
      tone_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result pin %0b playing %0b entry %0d done %0b",
                 $time, got.pin, got.playing, got.entry, got.done);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("pin_level", 32'(want.pin), 32'(got.pin));
      compare_field("playing", 32'(want.playing), 32'(got.playing));
      compare_field("current_entry", 32'(want.entry), 32'(got.entry));
      compare_field("sequence_done", 32'(want.done), 32'(got.done));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   opcode;
  logic [IDX_W-1:0]  entry_index;
  logic [FREQ_W-1:0] tone_freq_hz;
  logic [DUR_W-1:0]  duration_ms;
  logic              config_write;
  logic [IDX_W-1:0]  config_data;
  logic              valid;
  logic              pin_level;
  logic              playing;
  logic [POS_W-1:0]  current_entry;
  logic              sequence_done;

  tone_scoreboard sb = new();
  bit no_idle;
  int items_sent;
  int configs_written;

  pwm_tone_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .entry_index   (entry_index),
    .tone_freq_hz  (tone_freq_hz),
    .duration_ms   (duration_ms),
    .config_write  (config_write),
    .config_data   (config_data),
    .valid         (valid),
    .pin_level     (pin_level),
    .playing       (playing),
    .current_entry (current_entry),
    .sequence_done (sequence_done)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // every result transfer is checked at the edge that ends it
  always @(posedge clk) begin
    if (!rst && valid)
      sb.check_result(tone_result_t'{pin_level, playing, current_entry, sequence_done});
  end

  // one item transfer, after a random gap unless idling is off
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    entry_index <= idx;
    tone_freq_hz <= freq;
    duration_ms <= dur;
    do @(posedge clk); while (busy);
    if (op != OP_TICK || sb.running) items_sent++;
    sb.note_item(op, idx, freq, dur);
  endtask

  task automatic send_other(input logic [OP_W-1:0] op);
    send_item(op, IDX_W'($urandom), FREQ_W'($urandom), $urandom);
  endtask

  // mostly short high tones so sequences finish, sometimes anything
  task automatic load_tone(input int idx);
    if ($urandom_range(0, 4) != 0)
      send_item(OP_LOAD, IDX_W'(idx), FREQ_W'($urandom_range(50000, 65535)), '0);
    else
      send_item(OP_LOAD, IDX_W'(idx), FREQ_W'($urandom), $urandom);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_last_entry(input int v);
    config_write <= 1'b1;
    config_data <= IDX_W'(v);
    @(posedge clk);
    config_write <= 1'b0;
    sb.last_idx = IDX_W'(v);
    configs_written++;
  endtask

  // load the sequence, start it, then mostly ticks with some noise
  task automatic run_phase(input int last, input int body_len);
    int r;
    int stopped;
    drain_results();
    write_last_entry(last);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i <= last; i++) load_tone(i);
    send_other(OP_START);
    stopped = 0;
    for (int k = 0; k < body_len && stopped < 4 && items_sent < ITEM_TARGET; k++) begin
      r = $urandom_range(0, 99);
      if (r < 93) send_other(OP_TICK);
      else if (r < 96) send_other(OP_LOAD);
      else if (r < 98) send_other(OP_START);
      else send_other(OP_UNUSED);
      if (!sb.running) stopped++;
    end
  endtask

  initial begin
    int phase;
    int last;
    int body;
    int r;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_LOAD;
    entry_index = '0;
    tone_freq_hz = '0;
    duration_ms = '0;
    config_write = 1'b0;
    config_data = '0;
    no_idle = 1'b0;
    items_sent = 0;
    configs_written = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_last_entry(1);

    // directed: idle ticks, field extremes, restart and loads while playing
    send_other(OP_TICK);
    send_other(OP_UNUSED);
    send_item(OP_LOAD, 6'd0, 16'd0, 32'd0);
    send_item(OP_LOAD, 6'd1, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 6'd63, 16'hFFFF, 32'd0);
    send_item(OP_LOAD, 6'd2, 16'd1, 32'hFFFF_FFFF);
    send_other(OP_START);
    repeat (3) send_other(OP_TICK);
    send_other(OP_UNUSED);
    send_item(OP_LOAD, 6'd0, 16'd62500, 32'd0);
    send_other(OP_START);
    repeat (12) send_other(OP_TICK);

    // random sequences: largest table first, then the smallest, then mixed
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        last = 63;
        body = 40;
      end else if (phase == 1) begin
        last = 0;
        body = 250;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) last = $urandom_range(0, 1);
        else if (r < 9) last = $urandom_range(2, 3);
        else last = $urandom_range(4, 10);
        body = 180 * (last + 1) + $urandom_range(0, 100);
        if (body > 900) body = 900;
      end
      run_phase(last, body);
      phase++;
    end

    drain_results();
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
      sb.errors++;
    end
    $display("run covered %0d items over %0d last-entry settings",
             items_sent, configs_written);
    $display("%0d sequences played to the end, %0d mismatches",
             sb.finished_runs, sb.errors);
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // hard limit on the whole run
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ pwm_tone_sequencer.f @@
hdl/pts_pkg.sv
hdl/pts_alu.sv
hdl/pts_tables.sv
hdl/pwm_tone_sequencer.sv
hdl/pts_checker.sv
sim/tb_pwm_tone_sequencer.sv
